>>> rtl/rcle_pkg.sv
// Package for the rotor cipher letter engine.
// Holds the item types, item kind codes and default sizes. No dependencies.
package rcle_pkg;

    // Default sizes of the cipher.
    localparam int ROTOR_COUNT_DEF   = 5;
    localparam int ALPHABET_SIZE_DEF = 26;

    // First enciphered character, lowercase a.
    localparam logic [7:0] LETTER_A = 8'h61;

    // Item kinds.
    localparam logic [1:0] KIND_LOAD_ROTOR = 2'd0;
    localparam logic [1:0] KIND_LOAD_REFL  = 2'd1;
    localparam logic [1:0] KIND_CIPHER     = 2'd2;
    localparam logic [1:0] KIND_ZERO_POS   = 2'd3;

    // One input item.
    typedef struct packed {
        logic [1:0] kind;
        logic [2:0] rotor_number;
        logic [4:0] entry_index;
        logic [4:0] entry_value;
        logic [7:0] data_byte;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       was_enciphered;
    } t_out_item;

endpackage

>>> rtl/rotor_cipher_letter_engine_core.sv
// Rotor cipher letter engine with rotors and a reflector, no plugboard.
// A letter item steps through S_FWD per rotor, S_REFL, S_BWD per rotor in reverse and S_DONE
// into the result register, one table read per cycle in S_FWD and S_BWD; any other byte goes
// through S_PASS. No new item is taken until a cipher item is done; loads and position resets
// are taken every cycle; a stalled full result register in S_DONE or S_PASS holds input off.
// Synchronous active-low reset: positions to zero, reflector to identity, result register empty.
module rotor_cipher_letter_engine_core
    import rcle_pkg::*;
#(
    parameter int ROTOR_COUNT   = ROTOR_COUNT_DEF,
    parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    localparam int DEPTH = ROTOR_COUNT * ALPHABET_SIZE;
    localparam int AW    = $clog2(DEPTH);
    localparam int LW    = $clog2(ALPHABET_SIZE);
    localparam int RW    = (ROTOR_COUNT > 1) ? $clog2(ROTOR_COUNT) : 1;

    localparam logic [AW-1:0] A_AW        = AW'(ALPHABET_SIZE);
    localparam logic [LW:0]   A_W         = (LW + 1)'(ALPHABET_SIZE);
    localparam logic [LW-1:0] LAST_LETTER = LW'(ALPHABET_SIZE - 1);
    localparam logic [RW-1:0] LAST_ROTOR  = RW'(ROTOR_COUNT - 1);
    localparam logic [RW-1:0] FIRST_ROTOR = '0;

    // Sequencer states.
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_FWD  = 3'd1;
    localparam logic [2:0] S_REFL = 3'd2;
    localparam logic [2:0] S_BWD  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;
    localparam logic [2:0] S_PASS = 3'd5;

    // Modular add of two letter indexes.
    function automatic logic [LW-1:0] mod_add(input logic [LW-1:0] a, input logic [LW-1:0] b);
        logic [LW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= A_W) begin
            s = s - A_W;
        end
        return s[LW-1:0];
    endfunction

    // Modular subtract of a rotor position from a letter index.
    function automatic logic [LW-1:0] mod_sub(input logic [LW-1:0] v, input logic [LW-1:0] p);
        logic [LW:0] s;
        s = {1'b0, v} + A_W - {1'b0, p};
        if (s >= A_W) begin
            s = s - A_W;
        end
        return s[LW-1:0];
    endfunction

    logic [2:0]    r_state, n_state;
    logic [RW-1:0] r_rotor, n_rotor;
    logic [AW-1:0] r_base, n_base;
    logic [LW-1:0] r_idx, n_idx;
    logic          r_pend, n_pend;
    logic [LW-1:0] r_ppos, n_ppos;
    logic          r_pbwd, n_pbwd;
    logic [7:0]    r_byte, n_byte;
    logic [LW-1:0] r_pos [ROTOR_COUNT];
    logic [LW-1:0] n_pos [ROTOR_COUNT];
    logic [LW-1:0] step_pos [ROTOR_COUNT];
    logic [LW-1:0] r_refl [ALPHABET_SIZE];
    logic          r_ovalid, n_ovalid;
    t_out_item     r_oitem, n_oitem;

    logic          in_acc;
    logic          rotor_ok;
    logic          index_ok;
    logic          value_ok;
    logic          is_letter;
    logic [LW-1:0] ei_l;
    logic [LW-1:0] ev_l;
    logic [LW-1:0] letter_idx;
    logic [AW-1:0] wr_base;
    logic          tab_we;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [LW-1:0] q_fwd;
    logic [LW-1:0] q_inv;
    logic [LW-1:0] pos_cur;
    logic [LW-1:0] cur_idx;
    logic          slot_free;

    // Handshake and input decode.
    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign rotor_ok   = ({1'b0, i_in_item.rotor_number} < 4'(ROTOR_COUNT));
    assign index_ok   = ({1'b0, i_in_item.entry_index} < 6'(ALPHABET_SIZE));
    assign value_ok   = ({1'b0, i_in_item.entry_value} < 6'(ALPHABET_SIZE));
    assign is_letter  = ({1'b0, i_in_item.data_byte} >= {1'b0, LETTER_A})
                     && ({1'b0, i_in_item.data_byte} < ({1'b0, LETTER_A} + 9'(ALPHABET_SIZE)));
    assign ei_l       = i_in_item.entry_index[LW-1:0];
    assign ev_l       = i_in_item.entry_value[LW-1:0];
    assign letter_idx = LW'(i_in_item.data_byte - LETTER_A);

    // Rotor table write: forward entry and its inverse in the same cycle.
    assign wr_base = AW'(i_in_item.rotor_number) * A_AW;
    assign tab_we  = in_acc && (i_in_item.kind == KIND_LOAD_ROTOR)
                  && rotor_ok && index_ok && value_ok;

    // Letter index out of the previous lookup, or the held index.
    assign pos_cur = r_pos[r_rotor];
    assign cur_idx = r_pend ? mod_sub(r_pbwd ? q_inv : q_fwd, r_ppos) : r_idx;

    // One table read per cycle at the offset entry of the current rotor.
    assign rd_en   = (r_state == S_FWD) || (r_state == S_BWD);
    assign rd_addr = r_base + AW'(mod_add(cur_idx, pos_cur));

    rcle_ram #(
        .WIDTH (LW),
        .DEPTH (DEPTH)
    ) u_fwd_ram (
        .i_clk   (i_clk),
        .i_we    (tab_we),
        .i_waddr (wr_base + AW'(ei_l)),
        .i_wdata (ev_l),
        .i_re    (rd_en && (r_state == S_FWD)),
        .i_raddr (rd_addr),
        .o_rdata (q_fwd)
    );

    rcle_ram #(
        .WIDTH (LW),
        .DEPTH (DEPTH)
    ) u_inv_ram (
        .i_clk   (i_clk),
        .i_we    (tab_we),
        .i_waddr (wr_base + AW'(ev_l)),
        .i_wdata (ei_l),
        .i_re    (rd_en && (r_state == S_BWD)),
        .i_raddr (rd_addr),
        .o_rdata (q_inv)
    );

    // Odometer step of the rotor positions.
    always_comb begin : step_blk
        logic carry;
        carry = 1'b1;
        for (int r = 0; r < ROTOR_COUNT; r++) begin
            step_pos[r] = r_pos[r];
            if (carry) begin
                if (r_pos[r] == LAST_LETTER) begin
                    step_pos[r] = '0;
                end else begin
                    step_pos[r] = r_pos[r] + LW'(1);
                    carry       = 1'b0;
                end
            end
        end
    end

    assign slot_free = !r_ovalid || !i_out_stall;

    // Sequencer.
    always_comb begin
        n_state  = r_state;
        n_rotor  = r_rotor;
        n_base   = r_base;
        n_idx    = r_idx;
        n_pend   = r_pend;
        n_ppos   = r_ppos;
        n_pbwd   = r_pbwd;
        n_byte   = r_byte;
        n_pos    = r_pos;
        n_ovalid = r_ovalid;
        n_oitem  = r_oitem;

        // The result register empties when its item is taken.
        if (r_ovalid && !i_out_stall) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    unique case (i_in_item.kind)
                        KIND_LOAD_ROTOR, KIND_LOAD_REFL: begin
                            n_state = S_IDLE;
                        end
                        KIND_CIPHER: begin
                            if (is_letter) begin
                                n_state = S_FWD;
                                n_idx   = letter_idx;
                                n_rotor = FIRST_ROTOR;
                                n_base  = '0;
                                n_pend  = 1'b0;
                            end else begin
                                n_state = S_PASS;
                                n_byte  = i_in_item.data_byte;
                            end
                        end
                        KIND_ZERO_POS: begin
                            for (int r = 0; r < ROTOR_COUNT; r++) begin
                                n_pos[r] = '0;
                            end
                        end
                    endcase
                end
            end
            S_FWD: begin
                n_pend = 1'b1;
                n_ppos = pos_cur;
                n_pbwd = 1'b0;
                if (r_rotor == LAST_ROTOR) begin
                    n_state = S_REFL;
                end else begin
                    n_rotor = r_rotor + RW'(1);
                    n_base  = r_base + A_AW;
                end
            end
            S_REFL: begin
                n_idx   = r_refl[cur_idx];
                n_pend  = 1'b0;
                n_state = S_BWD;
            end
            S_BWD: begin
                n_pend = 1'b1;
                n_ppos = pos_cur;
                n_pbwd = 1'b1;
                if (r_rotor == FIRST_ROTOR) begin
                    n_state = S_DONE;
                end else begin
                    n_rotor = r_rotor - RW'(1);
                    n_base  = r_base - A_AW;
                end
            end
            S_DONE: begin
                if (slot_free) begin
                    n_ovalid                = 1'b1;
                    n_oitem.out_byte        = 8'(cur_idx) + LETTER_A;
                    n_oitem.was_enciphered  = 1'b1;
                    n_pos                   = step_pos;
                    n_pend                  = 1'b0;
                    n_state                 = S_IDLE;
                end
            end
            S_PASS: begin
                if (slot_free) begin
                    n_ovalid               = 1'b1;
                    n_oitem.out_byte       = r_byte;
                    n_oitem.was_enciphered = 1'b0;
                    n_state                = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state, rotor positions and reflector.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_rotor  <= FIRST_ROTOR;
            r_pend   <= 1'b0;
            r_ovalid <= 1'b0;
            for (int r = 0; r < ROTOR_COUNT; r++) begin
                r_pos[r] <= '0;
            end
            for (int i = 0; i < ALPHABET_SIZE; i++) begin
                r_refl[i] <= LW'(i);
            end
        end else begin
            r_state  <= n_state;
            r_rotor  <= n_rotor;
            r_pend   <= n_pend;
            r_ovalid <= n_ovalid;
            r_pos    <= n_pos;
            // Each reflector entry takes at most one of the two pair letters.
            if (in_acc && (i_in_item.kind == KIND_LOAD_REFL) && index_ok && value_ok) begin
                for (int i = 0; i < ALPHABET_SIZE; i++) begin
                    if (LW'(i) == ei_l) begin
                        r_refl[i] <= ev_l;
                    end else if (LW'(i) == ev_l) begin
                        r_refl[i] <= ei_l;
                    end
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_base  <= n_base;
        r_idx   <= n_idx;
        r_ppos  <= n_ppos;
        r_pbwd  <= n_pbwd;
        r_byte  <= n_byte;
        r_oitem <= n_oitem;
    end

    assign o_out_valid = r_ovalid;
    assign o_out_item  = r_oitem;

endmodule

>>> rtl/rcle_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module rcle_ram #(
    parameter int WIDTH = 5,
    parameter int DEPTH = 130
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port; the data holds while no read is enabled.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/rcle_checker.sv
// Port-level checks for the rotor cipher letter engine, bound to its top level.
// Depends on rcle_pkg and rotor_cipher_letter_engine_core.
module rcle_checker
    import rcle_pkg::*;
#(
    parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF
) (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input t_in_item  i_in_item,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_item
);

    // A stalled result item stays and holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("result item changed while stalled");

    // A cipher item keeps the block busy in the next cycle.
    a_cipher_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_in_item.kind == KIND_CIPHER) |=> o_in_stall)
        else $error("block ready right after a cipher item");

    // Loads and position resets leave the block ready in the next cycle.
    a_load_quick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_in_item.kind != KIND_CIPHER) |=> !o_in_stall)
        else $error("block busy after a load item");

    // An enciphered result is a lowercase letter of the alphabet.
    a_letter_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.was_enciphered |->
            ({1'b0, o_out_item.out_byte} >= {1'b0, LETTER_A})
            && ({1'b0, o_out_item.out_byte} < ({1'b0, LETTER_A} + 9'(ALPHABET_SIZE))))
        else $error("enciphered result outside the alphabet");

endmodule

bind rotor_cipher_letter_engine_core rcle_checker #(
    .ALPHABET_SIZE (ALPHABET_SIZE)
) u_rcle_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_item   (i_in_item),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);
